/* hdl/lzw_pkg.sv */
// Shared types and constants for the LZW encoder.
package lzw_pkg;

    localparam int BYTE_W    = 8;
    localparam int EPOCH_W   = 8;
    localparam int MAXCODE_W = 12;
    localparam logic [MAXCODE_W-1:0] MAXCODE_RST = 12'd4095;
    localparam int LITERALS  = 256;

    // One queued input request
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_req;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

endpackage

/* hdl/lzw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lzw_front.sv */
// Input request queue: two entries between the port and the back end.
module lzw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lzw_pkg::t_req        i_req,
    output logic                 o_req_valid,
    output lzw_pkg::t_req        o_req,
    input  logic                 i_req_pop
);
    import lzw_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_mem[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_req_pop && o_req_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Hold request payloads
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

/* hdl/lzw_core.sv */
// Back end: hashed dictionary search, insert, and result buffer.
module lzw_core #(
    parameter int CODE_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lzw_pkg::MAXCODE_W-1:0] i_cfg_data,
    input  logic                          i_req_valid,
    input  lzw_pkg::t_req                 i_req,
    output logic                          o_req_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [CODE_WIDTH-1:0]         o_out_code,
    output logic                          o_stream_end
);
    import lzw_pkg::*;

    localparam int CW     = CODE_WIDTH;
    localparam int KEY_W  = CW + BYTE_W;
    localparam int SLOT_W = EPOCH_W + KEY_W + CW;
    localparam int DEPTH  = 1 << CW;
    localparam int LW     = (CW > MAXCODE_W) ? CW : MAXCODE_W;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_clr, n_clr;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [CW-1:0]        r_prefix, n_prefix;
    logic                 r_pv, n_pv;
    logic [CW:0]          r_nfc, n_nfc;
    logic [MAXCODE_W-1:0] r_max;
    logic [CW-1:0]        r_addr, n_addr;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic                 r_last, n_last;
    logic [CW-1:0]        r_oq_code [2];
    logic                 r_oq_end  [2];
    logic [1:0]           r_ocnt;

    logic                 w_we;
    logic [CW-1:0]        w_waddr, w_raddr;
    logic [SLOT_W-1:0]    w_wdata, w_rdata;
    logic [KEY_W-1:0]     w_key, w_skey;
    logic [EPOCH_W-1:0]   w_sepoch;
    logic [CW-1:0]        w_scode;
    logic                 w_live, w_hit, w_miss;
    logic [LW-1:0]        w_max_ext, w_cap, w_limit;
    logic                 w_room, w_take, w_first_end;
    logic                 w_push1, w_push2;
    logic [CW-1:0]        w_code1, w_code2;
    logic                 w_end1;

    lzw_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(DEPTH)
    ) u_dict (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Decode slot read back from the dictionary
    assign w_key    = {r_prefix, r_byte};
    assign w_sepoch = w_rdata[SLOT_W-1 -: EPOCH_W];
    assign w_skey   = w_rdata[CW+KEY_W-1 -: KEY_W];
    assign w_scode  = w_rdata[CW-1:0];
    assign w_live   = (w_sepoch == r_epoch);
    assign w_hit    = (r_state == S_CHECK) && w_live && (w_skey == w_key);
    assign w_miss   = (r_state == S_CHECK) && !w_live;

    // Clamp the insertion limit to the code space
    assign w_max_ext = LW'(r_max);
    assign w_cap     = LW'(DEPTH - 1);
    assign w_limit   = (w_max_ext > w_cap) ? w_cap : w_max_ext;
    assign w_room    = ((LW+1)'(r_nfc) <= (LW+1)'(w_limit));

    assign w_take      = (r_state == S_IDLE) && i_req_valid && (r_ocnt == 2'd0);
    assign w_first_end = w_take && !r_pv && i_req.last_byte;
    assign o_req_pop   = w_take;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_take && r_pv) begin
                    n_state = S_READ;
                end else if (w_first_end && r_epoch == '1) begin
                    n_state = S_CLEAR;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_hit || w_miss) begin
                    n_state = (r_last && r_epoch == '1) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath, memory control and result pushes
    always_comb begin
        n_clr    = r_clr;
        n_epoch  = r_epoch;
        n_prefix = r_prefix;
        n_pv     = r_pv;
        n_nfc    = r_nfc;
        n_addr   = r_addr;
        n_byte   = r_byte;
        n_last   = r_last;
        w_we     = 1'b0;
        w_waddr  = r_addr;
        w_wdata  = '0;
        w_raddr  = r_addr;
        w_push1  = 1'b0;
        w_push2  = 1'b0;
        w_code1  = r_prefix;
        w_code2  = CW'(r_byte);
        w_end1   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == '1) n_epoch = EPOCH_W'(1);
            end
            S_IDLE: begin
                if (w_take) begin
                    n_byte = i_req.data_byte;
                    n_last = i_req.last_byte;
                    n_addr = r_prefix ^ (CW'(i_req.data_byte) << (CW - BYTE_W));
                    if (!r_pv) begin
                        n_prefix = CW'(i_req.data_byte);
                        n_pv     = 1'b1;
                        if (i_req.last_byte) begin
                            w_push1  = 1'b1;
                            w_code1  = CW'(i_req.data_byte);
                            w_end1   = 1'b1;
                            n_pv     = 1'b0;
                            n_prefix = '0;
                            n_nfc    = (CW+1)'(LITERALS);
                            n_epoch  = r_epoch + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                w_raddr = r_addr;
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_prefix = w_scode;
                    if (r_last) begin
                        w_push1 = 1'b1;
                        w_code1 = w_scode;
                        w_end1  = 1'b1;
                    end
                end else if (w_miss) begin
                    if (w_room) begin
                        w_we    = 1'b1;
                        w_wdata = {r_epoch, w_key, r_nfc[CW-1:0]};
                        n_nfc   = r_nfc + 1'b1;
                    end
                    w_push1  = 1'b1;
                    w_code1  = r_prefix;
                    n_prefix = CW'(r_byte);
                    w_push2  = r_last;
                end else begin
                    // probe the next slot
                    n_addr  = r_addr + 1'b1;
                    w_raddr = r_addr + 1'b1;
                end
                if ((w_hit || w_miss) && r_last) begin
                    n_pv     = 1'b0;
                    n_prefix = '0;
                    n_nfc    = (CW+1)'(LITERALS);
                    n_epoch  = r_epoch + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_epoch  <= '0;
            r_prefix <= '0;
            r_pv     <= 1'b0;
            r_nfc    <= (CW+1)'(LITERALS);
            r_max    <= MAXCODE_RST;
            r_ocnt   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_epoch  <= n_epoch;
            r_prefix <= n_prefix;
            r_pv     <= n_pv;
            r_nfc    <= n_nfc;
            if (i_cfg_we) r_max <= i_cfg_data;
            if (w_push1) begin
                r_ocnt <= w_push2 ? 2'd2 : 2'd1;
            end else if (r_ocnt != 2'd0 && i_ready) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    // Payload registers and result buffer
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_byte <= n_byte;
        r_last <= n_last;
        if (w_push1) begin
            r_oq_code[0] <= w_code1;
            r_oq_end[0]  <= w_end1;
            r_oq_code[1] <= w_code2;
            r_oq_end[1]  <= 1'b1;
        end else if (r_ocnt != 2'd0 && i_ready) begin
            r_oq_code[0] <= r_oq_code[1];
            r_oq_end[0]  <= r_oq_end[1];
        end
    end

    assign o_valid      = (r_ocnt != 2'd0);
    assign o_out_code   = r_oq_code[0];
    assign o_stream_end = r_oq_end[0];

endmodule

/* hdl/lzw_encoder.sv */
// LZW encoder top level: request queue, dictionary engine and result buffer.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  input   | in        | i_valid / o_ready   | i_data_byte, i_last_byte
//  output  | out       | o_valid / i_ready   | o_out_code, o_stream_end
//  config  | in        | i_cfg_we            | i_cfg_data (max_code)
//
// The first byte of a stream is taken in S_IDLE alone; any other byte passes
// S_IDLE, S_READ and S_CHECK, staying in S_CHECK for each extra probe of the
// linear-probed hash table, which has a single registered read port. Up to two
// results per byte drain from a two-entry buffer before the engine takes the
// next request; a two-entry queue keeps accepting input meanwhile. After reset
// and every 255 streams, all 2^CODE_WIDTH slots are cleared with no request taken.
module lzw_encoder #(
    parameter int CODE_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lzw_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [CODE_WIDTH-1:0]         o_out_code,
    output logic                          o_stream_end,
    input  logic                          i_cfg_we,
    input  logic [lzw_pkg::MAXCODE_W-1:0] i_cfg_data
);
    import lzw_pkg::*;

    t_req w_in_req, w_q_req;
    logic w_q_valid, w_q_pop;

    assign w_in_req.data_byte = i_data_byte;
    assign w_in_req.last_byte = i_last_byte;

    lzw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (w_in_req),
        .o_req_valid(w_q_valid),
        .o_req      (w_q_req),
        .i_req_pop  (w_q_pop)
    );

    lzw_core #(
        .CODE_WIDTH(CODE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (w_q_valid),
        .i_req       (w_q_req),
        .o_req_pop   (w_q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_code  (o_out_code),
        .o_stream_end(o_stream_end)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the LZW encoder: directed table, random streams, idling and stall.
`timescale 1ns / 1ps

module testbench;

    import lzw_pkg::*;

    localparam int CODE_W    = 12;
    localparam int CODE_TOP  = (1 << CODE_W) - 1;
    localparam int DICT_SIZE = (1 << CODE_W) - LITERALS;
    localparam int WATCHDOG  = 40000;

    // Idling modes: sender 31 / receiver 53, sender 53 / receiver 31, none
    localparam int MODE_RECV_SLOW = 0;
    localparam int MODE_SEND_SLOW = 1;
    localparam int MODE_NO_IDLE   = 2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              stream_end;
    } t_code_out;

    // Directed row: byte, last flag, number of typed-in codes, codes
    typedef struct {
        logic [7:0]        data_byte;
        logic              last_byte;
        int                n_typed;
        t_code_out         typed [2];
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 i_last_byte;
    logic                 o_valid;
    logic                 i_ready;
    logic [CODE_W-1:0]    o_out_code;
    logic                 o_stream_end;
    logic                 i_cfg_we;
    logic [MAXCODE_W-1:0] i_cfg_data;

    // Predictor state
    logic [19:0]          dict_keys [DICT_SIZE];
    logic [CODE_W-1:0]    cur_prefix;
    logic                 have_prefix;
    logic [12:0]          free_code;
    logic [MAXCODE_W-1:0] code_limit;

    t_code_out            pending_codes [$];
    int                   errors;
    int                   mode;
    int                   idle_cycles;
    bit                   hold_off;
    bit                   done_flag;

    lzw_encoder #(.CODE_WIDTH(CODE_W)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_code   (o_out_code),
        .o_stream_end (o_stream_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Reset the compression state at the end of a stream
    function automatic void close_stream();
        have_prefix = 1'b0;
        cur_prefix  = '0;
        free_code   = 13'(LITERALS);
    endfunction

    // Advance the encoder state by one byte and queue the codes it emits
    function automatic void encode_byte(logic [7:0] b, logic last);
        logic [19:0] key;
        int          hit;
        int          lim;
        lim = (code_limit > CODE_TOP) ? CODE_TOP : int'(code_limit);
        if (!have_prefix) begin
            cur_prefix  = CODE_W'(b);
            have_prefix = 1'b1;
        end else begin
            key = {cur_prefix, b};
            hit = 0;
            for (int c = LITERALS; c < int'(free_code) && c <= CODE_TOP; c++) begin
                if (hit == 0 && dict_keys[c - LITERALS] == key) hit = c;
            end
            if (hit != 0) begin
                cur_prefix = CODE_W'(hit);
            end else begin
                if (int'(free_code) <= lim) begin
                    dict_keys[int'(free_code) - LITERALS] = key;
                    free_code++;
                end
                pending_codes.push_back('{cur_prefix, 1'b0});
                cur_prefix = CODE_W'(b);
            end
        end
        if (last) begin
            pending_codes.push_back('{cur_prefix, 1'b1});
            close_stream();
        end
    endfunction

    // Chance in percent that the sender idles for a cycle
    function automatic int send_idle_pct();
        case (mode)
            MODE_RECV_SLOW: send_idle_pct = 31;
            MODE_SEND_SLOW: send_idle_pct = 53;
            default:        send_idle_pct = 0;
        endcase
    endfunction

    // Offer one request and hold it until accepted; valid stays up on return
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_byte(b, last);
        @(negedge i_clk);
    endtask

    // Wait until every code has come back, then let the engine settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_codes.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [MAXCODE_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        code_limit  = v;
    endtask

    // Send a random stream: mostly a small alphabet so the dictionary gets hits
    task automatic send_stream(int len);
        logic [7:0] b;
        int         span;
        span = $urandom_range(3) == 0 ? 255 : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
            b = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(span));
            send_byte(b, k == len - 1);
        end
    endtask

    // Drive the receiver side, with a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off) begin
            i_ready <= 1'b0;
        end else if (mode == MODE_RECV_SLOW) begin
            i_ready <= ($urandom_range(99) >= 53);
        end else if (mode == MODE_SEND_SLOW) begin
            i_ready <= ($urandom_range(99) >= 31);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check each accepted code against the oldest prediction
    always @(posedge i_clk) begin
        t_code_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected code, expected none, actual %0d end %0b",
                         $realtime, o_out_code, o_stream_end);
                errors++;
            end else begin
                want = pending_codes.pop_front();
                if (o_out_code !== want.code) begin
                    $display("%0t: out_code mismatch, expected %0d, actual %0d",
                             $realtime, want.code, o_out_code);
                    errors++;
                end
                if (o_stream_end !== want.stream_end) begin
                    $display("%0t: stream_end mismatch, expected %0b, actual %0b",
                             $realtime, want.stream_end, o_stream_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with neither an accepted request nor an accepted code
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || done_flag) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_code_out got;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = MAXCODE_RST;
        i_ready     = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        hold_off    = 1'b0;
        done_flag   = 1'b0;
        mode        = MODE_RECV_SLOW;
        code_limit  = MAXCODE_RST;
        close_stream();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: single-byte streams, extremes, repeats, last-byte miss
        rows.push_back('{8'd0,   1'b1, 1, '{'{12'd0, 1'b1}, '0}});
        rows.push_back('{8'd255, 1'b1, 1, '{'{12'd255, 1'b1}, '0}});
        rows.push_back('{8'h41,  1'b0, 0, '{'0, '0}});
        rows.push_back('{8'h42,  1'b0, 1, '{'{12'h41, 1'b0}, '0}});
        rows.push_back('{8'h41,  1'b0, 1, '{'{12'h42, 1'b0}, '0}});
        rows.push_back('{8'h42,  1'b0, 0, '{'0, '0}});
        rows.push_back('{8'h41,  1'b0, -1, '{'0, '0}});
        rows.push_back('{8'h42,  1'b0, -1, '{'0, '0}});
        rows.push_back('{8'hAA,  1'b1, -1, '{'0, '0}});
        rows.push_back('{8'h55,  1'b0, 0, '{'0, '0}});
        rows.push_back('{8'hAA,  1'b1, 2, '{'{12'h55, 1'b0}, '{12'hAA, 1'b1}}});
        rows.push_back('{8'h07,  1'b0, 0, '{'0, '0}});
        rows.push_back('{8'h07,  1'b0, -1, '{'0, '0}});
        rows.push_back('{8'h07,  1'b0, -1, '{'0, '0}});
        rows.push_back('{8'h07,  1'b1, -1, '{'0, '0}});
        foreach (rows[r]) begin
            send_byte(rows[r].data_byte, rows[r].last_byte);
            if (rows[r].n_typed >= 0) begin
                if (pending_codes.size() < rows[r].n_typed) begin
                    $display("%0t: row %0d expected %0d codes, predicted %0d", $realtime,
                             r, rows[r].n_typed, pending_codes.size());
                    errors++;
                end
                for (int k = 0; k < rows[r].n_typed && k < pending_codes.size(); k++) begin
                    got = pending_codes[pending_codes.size() - rows[r].n_typed + k];
                    if (got !== rows[r].typed[k]) begin
                        $display("%0t: row %0d expected %0d/%0b, predicted %0d/%0b",
                                 $realtime, r, rows[r].typed[k].code,
                                 rows[r].typed[k].stream_end, got.code, got.stream_end);
                        errors++;
                    end
                end
            end
        end
        drain();

        // Random streams across several limits, including full-dictionary cases
        for (int ph = 0; ph < 6; ph++) begin
            mode = (ph < 2) ? MODE_RECV_SLOW : (ph < 4) ? MODE_SEND_SLOW : MODE_NO_IDLE;
            case (ph)
                0: write_limit(12'd0);
                1: write_limit(12'd258);
                2: write_limit(12'd4095);
                3: write_limit(12'd300);
                4: write_limit(12'd255);
                default: write_limit(12'($urandom_range(256, 4095)));
            endcase
            for (int s = 0; s < 16; s++) begin
                // Hold off the receiver while requests keep coming
                if (ph == 2 && s == 3) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(negedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                // Pause the sender until all codes are back
                if (s == 7) begin
                    i_valid <= 1'b0;
                    while (pending_codes.size() != 0) @(negedge i_clk);
                end
                send_stream($urandom_range(1, 22));
            end
            drain();
        end

        done_flag = 1'b1;
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
